// File: sv/rmth_pkg.sv
package rmth_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned MEDIAN_W     = 33;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned S_TDATA_W    = 32;
  localparam int unsigned M_TDATA_W    = 48;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECIDE,
    OP_RT_CHK,
    OP_RT_CMP,
    OP_PU_INIT,
    OP_PU_CHK,
    OP_PU_CMP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic swap;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/rmth_ctrl.sv
module rmth_ctrl import rmth_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_RT_CHK  = 3'd2;
  localparam logic [2:0] S_RT_CMP  = 3'd3;
  localparam logic [2:0] S_PU_INIT = 3'd4;
  localparam logic [2:0] S_PU_CHK  = 3'd5;
  localparam logic [2:0] S_PU_CMP  = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0] state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        if (sts_i.full) begin
          state_d = S_FINISH;
        end else if (sts_i.swap) begin
          state_d = S_RT_CHK;
        end else begin
          state_d = S_PU_CHK;
        end
      end
      S_RT_CHK: begin
        cmd_o.op = OP_RT_CHK;
        state_d  = sts_i.last ? S_PU_INIT : S_RT_CMP;
      end
      S_RT_CMP: begin
        cmd_o.op = OP_RT_CMP;
        state_d  = sts_i.last ? S_PU_INIT : S_RT_CHK;
      end
      S_PU_INIT: begin
        cmd_o.op = OP_PU_INIT;
        state_d  = S_PU_CHK;
      end
      S_PU_CHK: begin
        cmd_o.op = OP_PU_CHK;
        state_d  = sts_i.last ? S_FINISH : S_PU_CMP;
      end
      S_PU_CMP: begin
        cmd_o.op = OP_PU_CMP;
        state_d  = sts_i.last ? S_FINISH : S_PU_CHK;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/rmth_dp.sv
module rmth_dp import rmth_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic                 m_tuser_o
);

  localparam int unsigned DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = AW + 2;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  function automatic logic above_f(input logic is_min,
                                   input logic signed [SAMPLE_W-1:0] a,
                                   input logic signed [SAMPLE_W-1:0] b);
    return is_min ? (a < b) : (a > b);
  endfunction

  logic signed [SAMPLE_W-1:0] mem_up [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_lo [DEPTH];

  logic [CW-1:0]              held_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, val_q, carry_q, top_up_q, top_lo_q;
  logic signed [SAMPLE_W-1:0] rd_up_a_q, rd_up_b_q, rd_lo_a_q, rd_lo_b_q;
  logic [AW-1:0]              idx_q;
  logic [XW-1:0]              size_q;
  logic                       heap_q;
  logic [MEDIAN_W-1:0]        median_q;
  logic [COUNT_W-1:0]         count_q;
  logic                       rej_q;

  logic                       full, even, swap, last, we;
  logic [CW:0]                held_p1;
  logic [CW-1:0]              rt_size, push_size, held_n;
  logic [XW-1:0]              c_w, c1_w;
  logic [AW-1:0]              idx_m1, parent, ra, rb, pick_idx;
  logic signed [SAMPLE_W-1:0] ha, hb, pick, wdata;
  logic                       pick_b;
  logic signed [MEDIAN_W-1:0] median_n;

  assign full      = (held_q >= CAP_C);
  assign even      = ~held_q[0];
  assign held_p1   = {1'b0, held_q} + 1'b1;
  assign rt_size   = held_p1[CW:1];
  assign push_size = {1'b0, held_q[CW-1:1]};
  assign swap      = even ? ((|held_q[CW-1:1]) && (sample_q < top_lo_q))
                          : (sample_q > top_up_q);

  assign c_w    = XW'({idx_q, 1'b1});
  assign c1_w   = c_w + XW'(1);
  assign idx_m1 = idx_q - AW'(1);
  assign parent = idx_m1 >> 1;
  assign ra     = (cmd_i.op == OP_RT_CHK) ? c_w[AW-1:0] : parent;
  assign rb     = c1_w[AW-1:0];

  assign ha       = heap_q ? rd_up_a_q : rd_lo_a_q;
  assign hb       = heap_q ? rd_up_b_q : rd_lo_b_q;
  assign pick_b   = (c1_w < size_q) && above_f(heap_q, hb, ha);
  assign pick     = pick_b ? hb : ha;
  assign pick_idx = pick_b ? c1_w[AW-1:0] : c_w[AW-1:0];

  always_comb begin
    case (cmd_i.op)
      OP_RT_CHK: last = (c_w >= size_q);
      OP_RT_CMP: last = !above_f(heap_q, pick, val_q);
      OP_PU_CHK: last = (idx_q == '0);
      OP_PU_CMP: last = !above_f(heap_q, val_q, ha);
      default:   last = 1'b0;
    endcase
  end

  assign we = ((cmd_i.op == OP_RT_CHK || cmd_i.op == OP_PU_CHK) && last) ||
              cmd_i.op == OP_RT_CMP || cmd_i.op == OP_PU_CMP;
  assign wdata = last ? val_q : ((cmd_i.op == OP_RT_CMP) ? pick : ha);

  assign held_n   = full ? held_q : held_p1[CW-1:0];
  assign median_n = held_n[0] ? {top_up_q, 1'b0}
                              : (MEDIAN_W'(top_up_q) + MEDIAN_W'(top_lo_q));

  assign sts_o.full     = full;
  assign sts_o.swap     = swap;
  assign sts_o.last     = last;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(M_TDATA_W - MEDIAN_W - COUNT_W){1'b0}}, count_q, median_q};
  assign m_tuser_o  = rej_q;

  always_ff @(posedge clk_i) begin
    if (we && heap_q) begin
      mem_up[idx_q] <= wdata;
    end
    if (we && !heap_q) begin
      mem_lo[idx_q] <= wdata;
    end
    rd_up_a_q <= mem_up[ra];
    rd_up_b_q <= mem_up[rb];
    rd_lo_a_q <= mem_lo[ra];
    rd_lo_b_q <= mem_lo[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FINISH) begin
        held_q      <= held_n;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && idx_q == '0) begin
      if (heap_q) begin
        top_up_q <= wdata;
      end else begin
        top_lo_q <= wdata;
      end
    end
    case (cmd_i.op)
      OP_LOAD: begin
        sample_q <= signed'(s_tdata_i[SAMPLE_W-1:0]);
      end
      OP_DECIDE: begin
        val_q <= sample_q;
        if (swap) begin
          heap_q  <= ~even;
          idx_q   <= '0;
          size_q  <= XW'(rt_size);
          carry_q <= even ? top_lo_q : top_up_q;
        end else begin
          heap_q <= even;
          idx_q  <= AW'(push_size);
        end
      end
      OP_RT_CMP: begin
        if (!last) begin
          idx_q <= pick_idx;
        end
      end
      OP_PU_INIT: begin
        heap_q <= ~heap_q;
        idx_q  <= AW'(push_size);
        val_q  <= carry_q;
      end
      OP_PU_CMP: begin
        if (!last) begin
          idx_q <= parent;
        end
      end
      OP_FINISH: begin
        median_q <= median_n;
        count_q  <= COUNT_W'(held_n);
        rej_q    <= full;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/running_median_two_heaps.sv
// Each input transaction runs through at most two sift loops before its result (a check state
// and a compare state per heap level, one memory read port pair per heap).
// Input is taken only when idle, so a new sample is not taken before the last one is through;
// the next sample is taken while a result waits, which then stalls before its result.
// Reset: asynchronous, active low; clears the sample count and output valid.
// Heap memories are not cleared; no entry is used before it is written.
module running_median_two_heaps import rmth_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [32:0] median_times_two, [43:33] element_count
  output logic                 m_axis_tuser    // [0] rejected_full
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rmth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmth_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

`ifndef SYNTH
  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  a_rej_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[43:33] == CAP_CNT))
    else $error("rejected transaction below capacity");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[43:33] != '0))
    else $error("result with zero count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a transaction is in progress");
`endif

endmodule
